/* hdl/bsgr_pkg.sv */
// Shared types and constants for the battery supervisor with gain ramp.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package bsgr_pkg;

  // Request types
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_VOLT = 3'd1;
  localparam logic [2:0] REQ_CAP  = 3'd2;
  localparam logic [2:0] REQ_FULL = 3'd3;
  localparam logic [2:0] REQ_PEER = 3'd4;

  // Link roles
  localparam logic [1:0] ROLE_MASTER = 2'd1;
  localparam logic [1:0] ROLE_SLAVE  = 2'd2;

  // Event kinds
  localparam logic [2:0] KIND_GAIN    = 3'd0;
  localparam logic [2:0] KIND_CAP     = 3'd1;
  localparam logic [2:0] KIND_SYNC    = 3'd2;
  localparam logic [2:0] KIND_FULL    = 3'd3;
  localparam logic [2:0] KIND_TOO_LOW = 3'd4;
  localparam logic [2:0] KIND_LOW     = 3'd5;

  // Ramp directions
  localparam logic [1:0] RAMP_NONE = 2'd0;
  localparam logic [1:0] RAMP_UP   = 2'd1;
  localparam logic [1:0] RAMP_DOWN = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_SHUTDOWN = 2'd0;
  localparam logic [1:0] REG_WARNING  = 2'd1;
  localparam logic [1:0] REG_STEP     = 2'd2;
  localparam logic [1:0] REG_PERIOD   = 2'd3;

  localparam logic [22:0] RST_SHUTDOWN_UV = 23'd3400000;
  localparam logic [22:0] RST_WARNING_UV  = 23'd3600000;
  localparam logic [15:0] RST_STEP_TICKS  = 16'd30;
  localparam logic [31:0] RST_PERIOD_MS   = 32'd60000;
  localparam logic [6:0]  RST_PEER_CAP    = 7'd100;

  localparam logic [6:0]        LOW_CAP_LIMIT = 7'd15;
  localparam logic signed [5:0] GAIN_FLOOR    = -6'sd20;
  localparam logic signed [5:0] GAIN_STEP     = 6'sd5;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [22:0] shutdown_uv;
    logic [22:0] warning_uv;
    logic [15:0] step_ticks;
    logic [31:0] low_period_ms;
  } cfg_t;

  // Results of one tick, one valid flag per possible event.
  typedef struct packed {
    logic               gain_vld;
    logic signed [5:0]  gain;
    logic               rpt_vld;
    logic               rpt_sync;
    logic [30:0]        rpt_value;
    logic               full_vld;
    logic               volt_vld;
    logic               volt_low;
  } rec_t;

endpackage

/* hdl/bsgr_front.sv */
// Front part: accepts requests, keeps the supervisor state and works out the
// results of each tick as one record. Depends on bsgr_pkg.
`timescale 1ns / 1ps

module bsgr_front import bsgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [2:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [22:0] voltage_uv,
  input  logic [6:0]  capacity_pct,
  input  logic [1:0]  link_role,
  output logic        push,
  output rec_t        rec
);

  logic [22:0]       batt_volt, batt_volt_next;
  logic [6:0]        batt_cap, batt_cap_next;
  logic [6:0]        peer_cap, peer_cap_next;
  logic              cap_pend, cap_pend_next;
  logic              full_pend, full_pend_next;
  logic signed [5:0] post_gain, post_gain_next;
  logic [1:0]        ramp_dir, ramp_dir_next;
  logic [15:0]       ramp_ticks, ramp_ticks_next;
  logic [31:0]       last_low, last_low_next;

  logic [1:0]        dir_s;
  logic [15:0]       ticks_s;
  logic              step_now;
  logic              done;
  logic signed [5:0] gain_up, gain_dn, gain_s;
  logic [6:0]        min_cap;
  logic [31:0]       since_low;
  logic              low_due;

  // Gain ramp; a capacity change may restart it with the counter saturated.
  always_comb begin
    dir_s   = ramp_dir;
    ticks_s = ramp_ticks;
    if (cap_pend) begin
      if (batt_cap < LOW_CAP_LIMIT && !post_gain[5]) begin
        dir_s   = RAMP_DOWN;
        ticks_s = '1;
      end
      if (batt_cap >= LOW_CAP_LIMIT && post_gain[5]) begin
        dir_s   = RAMP_UP;
        ticks_s = '1;
      end
    end
    step_now = (dir_s != RAMP_NONE) && (ticks_s >= cfg.step_ticks);
    gain_up  = post_gain + GAIN_STEP;
    gain_dn  = post_gain - GAIN_STEP;
    gain_s   = post_gain;
    done     = 1'b0;
    if (step_now) begin
      if (dir_s == RAMP_UP && post_gain < 0) begin
        if (!gain_up[5]) begin
          gain_s = '0;
          done   = 1'b1;
        end else begin
          gain_s = gain_up;
        end
      end
      if (dir_s == RAMP_DOWN && post_gain > GAIN_FLOOR) begin
        if (gain_dn <= GAIN_FLOOR) begin
          gain_s = GAIN_FLOOR;
          done   = 1'b1;
        end else begin
          gain_s = gain_dn;
        end
      end
    end
  end

  assign min_cap   = (batt_cap > peer_cap) ? peer_cap : batt_cap;
  assign since_low = now_ms - last_low;
  assign low_due   = (since_low >= cfg.low_period_ms) || (last_low == '0);

  always_comb begin
    batt_volt_next  = batt_volt;
    batt_cap_next   = batt_cap;
    peer_cap_next   = peer_cap;
    cap_pend_next   = cap_pend;
    full_pend_next  = full_pend;
    post_gain_next  = post_gain;
    ramp_dir_next   = ramp_dir;
    ramp_ticks_next = ramp_ticks;
    last_low_next   = last_low;
    rec             = '0;
    if (accept) begin
      unique case (req_type)
        REQ_VOLT: batt_volt_next = voltage_uv;
        REQ_CAP: begin
          batt_cap_next = capacity_pct;
          cap_pend_next = 1'b1;
        end
        REQ_FULL: full_pend_next = 1'b1;
        REQ_PEER: begin
          peer_cap_next = capacity_pct;
          cap_pend_next = 1'b1;
        end
        REQ_TICK: begin
          if (dir_s != RAMP_NONE) begin
            post_gain_next  = gain_s;
            ramp_dir_next   = done ? RAMP_NONE : dir_s;
            ramp_ticks_next = step_now ? 16'd1 : ticks_s + 16'd1;
          end
          rec.gain_vld = step_now;
          rec.gain     = gain_s;
          if (cap_pend) begin
            cap_pend_next = 1'b0;
            if (link_role == ROLE_SLAVE) begin
              rec.rpt_vld   = 1'b1;
              rec.rpt_sync  = 1'b1;
              rec.rpt_value = {batt_cap, 1'b0, batt_volt};
            end else if (link_role == ROLE_MASTER) begin
              rec.rpt_vld   = 1'b1;
              rec.rpt_value = {24'd0, min_cap};
            end else begin
              rec.rpt_vld   = 1'b1;
              rec.rpt_value = {24'd0, batt_cap};
            end
          end
          if (full_pend) begin
            full_pend_next = 1'b0;
            rec.full_vld   = 1'b1;
          end
          if (batt_volt <= cfg.shutdown_uv) begin
            rec.volt_vld = 1'b1;
          end else if (batt_volt <= cfg.warning_uv && low_due) begin
            rec.volt_vld  = (link_role != ROLE_SLAVE);
            rec.volt_low  = 1'b1;
            last_low_next = now_ms;
          end
        end
        default: ;
      endcase
    end
  end

  assign push = rec.gain_vld | rec.rpt_vld | rec.full_vld | rec.volt_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      batt_volt  <= '0;
      batt_cap   <= '0;
      peer_cap   <= RST_PEER_CAP;
      cap_pend   <= 1'b0;
      full_pend  <= 1'b0;
      post_gain  <= '0;
      ramp_dir   <= RAMP_NONE;
      ramp_ticks <= '0;
      last_low   <= '0;
    end else begin
      batt_volt  <= batt_volt_next;
      batt_cap   <= batt_cap_next;
      peer_cap   <= peer_cap_next;
      cap_pend   <= cap_pend_next;
      full_pend  <= full_pend_next;
      post_gain  <= post_gain_next;
      ramp_dir   <= ramp_dir_next;
      ramp_ticks <= ramp_ticks_next;
      last_low   <= last_low_next;
    end
  end

endmodule

/* hdl/bsgr_queue.sv */
// Short record queue between the front and back parts.
// Depends on bsgr_pkg for the record type and depth.
`timescale 1ns / 1ps

module bsgr_queue import bsgr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_data,
  input  logic pop,
  output logic full,
  output logic avail,
  output rec_t pop_data
);

  rec_t              mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_CW-1:0]   count;

  assign full     = (count == Q_CW'(Q_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CW'(push) - Q_CW'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !avail))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

/* hdl/bsgr_back.sv */
// Back part: takes tick records from the queue and sends their events one per
// cycle while not stalled, through an output register. Depends on bsgr_pkg.
`timescale 1ns / 1ps

module bsgr_back import bsgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  rec_t              q_data,
  output logic              pop,
  output logic              evt_valid,
  input  logic              evt_stall,
  output logic [2:0]        event_kind,
  output logic signed [5:0] gain_tenth_db,
  output logic [30:0]       report_value,
  output logic              last_of_run
);

  rec_t        cur;
  logic [3:0]  flags;
  logic [3:0]  sel, rem;
  logic        out_free, emit;
  logic [2:0]  kind_s;
  logic [5:0]  gain_s;
  logic [30:0] value_s;

  // Events leave in order gain, capacity, charge full, voltage.
  assign sel      = flags & (~flags + 4'd1);
  assign rem      = flags & ~sel;
  assign out_free = !evt_valid || !evt_stall;
  assign emit     = (flags != '0) && out_free;
  assign pop      = q_avail && ((flags == '0) || (emit && rem == '0));

  always_comb begin
    kind_s  = KIND_GAIN;
    gain_s  = '0;
    value_s = '0;
    priority if (sel[0]) begin
      gain_s = cur.gain;
    end else if (sel[1]) begin
      kind_s  = cur.rpt_sync ? KIND_SYNC : KIND_CAP;
      value_s = cur.rpt_value;
    end else if (sel[2]) begin
      kind_s = KIND_FULL;
    end else begin
      kind_s = cur.volt_low ? KIND_LOW : KIND_TOO_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (emit) begin
      event_kind    <= kind_s;
      gain_tenth_db <= gain_s;
      report_value  <= value_s;
      last_of_run   <= (rem == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (pop) begin
        flags <= {q_data.volt_vld, q_data.full_vld, q_data.rpt_vld, q_data.gain_vld};
      end else if (emit) begin
        flags <= rem;
      end
      if (emit) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

  a_pop_only_when_done: assert property (@(posedge clk) disable iff (rst)
                                         pop |-> (flags == '0 || rem == '0))
    else $error("record replaced while events remain");
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
      (evt_valid && event_kind == KIND_GAIN) |->
      (gain_tenth_db <= 6'sd0 && gain_tenth_db >= GAIN_FLOOR))
    else $error("gain outside ramp range");
  a_last_ends_record: assert property (@(posedge clk) disable iff (rst)
      (emit && rem == '0) |=> (evt_valid && last_of_run))
    else $error("final event of a tick not marked");

endmodule

/* hdl/battery_supervisor_with_gain_ramp.sv */
// Top level of the battery supervisor: configuration registers and the
// front, queue and back parts. Depends on bsgr_pkg, bsgr_front, bsgr_queue, bsgr_back.
// The first event of a tick passes the record queue, the back record register and its output register.
// Unless stalled: one request per cycle; a tick's events leave one per cycle (up to 4).
// The back part's single output register sets the event rate.
// Reset (synchronous, active high) restores the register defaults and clears the state;
// the peer capacity starts at 100.
`timescale 1ns / 1ps

module battery_supervisor_with_gain_ramp import bsgr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [2:0]        req_type,
  input  logic [31:0]       now_ms,
  input  logic [22:0]       voltage_uv,
  input  logic [6:0]        capacity_pct,
  input  logic [1:0]        link_role,
  output logic              evt_valid,
  input  logic              evt_stall,
  output logic [2:0]        event_kind,
  output logic signed [5:0] gain_tenth_db,
  output logic [30:0]       report_value,
  output logic              last_of_run,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic cfg_wr;
  logic accept;
  logic push, pop, q_full, q_avail;
  rec_t push_rec, pop_rec;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shutdown_uv   <= RST_SHUTDOWN_UV;
      cfg.warning_uv    <= RST_WARNING_UV;
      cfg.step_ticks    <= RST_STEP_TICKS;
      cfg.low_period_ms <= RST_PERIOD_MS;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SHUTDOWN: cfg.shutdown_uv   <= pwdata[22:0];
        REG_WARNING:  cfg.warning_uv    <= pwdata[22:0];
        REG_STEP:     cfg.step_ticks    <= pwdata[15:0];
        REG_PERIOD:   cfg.low_period_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SHUTDOWN: prdata = {9'd0, cfg.shutdown_uv};
      REG_WARNING:  prdata = {9'd0, cfg.warning_uv};
      REG_STEP:     prdata = {16'd0, cfg.step_ticks};
      REG_PERIOD:   prdata = cfg.low_period_ms;
      default:      prdata = '0;
    endcase
  end

  // Requests are held off only while the record queue is full.
  assign req_stall = q_full;
  assign accept    = req_valid && !req_stall;

  bsgr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .req_type     (req_type),
    .now_ms       (now_ms),
    .voltage_uv   (voltage_uv),
    .capacity_pct (capacity_pct),
    .link_role    (link_role),
    .push         (push),
    .rec          (push_rec)
  );

  bsgr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .full      (q_full),
    .avail     (q_avail),
    .pop_data  (pop_rec)
  );

  bsgr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_avail       (q_avail),
    .q_data        (pop_rec),
    .pop           (pop),
    .evt_valid     (evt_valid),
    .evt_stall     (evt_stall),
    .event_kind    (event_kind),
    .gain_tenth_db (gain_tenth_db),
    .report_value  (report_value),
    .last_of_run   (last_of_run)
  );

endmodule
